FILE: hw/rtl/cht_pkg.sv
// Shared types and constants for the cuckoo hash table.
package cht_pkg;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_FIND   = 2'd1;
   localparam logic [1:0] FUNC_ERASE  = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   localparam logic [2:0] ST_PRESENT   = 3'd0;
   localparam logic [2:0] ST_PLACED    = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FAILED    = 3'd4;
   localparam logic [2:0] ST_ERASED    = 3'd5;
   localparam logic [2:0] ST_READ      = 3'd6;

   localparam int          FUNC_W   = 2;
   localparam int          HASH_W   = 32;
   localparam int          SLOTF_W  = 10;
   localparam int          STATUS_W = 3;
   localparam int          COUNT_W  = 11;
   localparam int          DEPTH_W  = 7;
   localparam logic [6:0]  EVICT_RESET = 7'd8;

   // Table geometry; the depth is a power of two, so a slot is the low hash bits.
   localparam int          TABLE_DEPTH = 1024;
   localparam int          KEY_BITS    = 32;
   localparam int          IDX_W       = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

   // Memory command from the sequencer to the slot store.
   typedef struct packed {
      logic rd;
      logic wr;
      logic set_valid;
      logic clr_valid;
   } mem_cmd_type;

   // Request word.
   typedef struct packed {
      logic [FUNC_W-1:0]   req_func;
      logic [KEY_BITS-1:0] req_key;
      logic [HASH_W-1:0]   req_hash_first;
      logic [HASH_W-1:0]   req_hash_second;
      logic [SLOTF_W-1:0]  req_slot_index;
   } req_word_type;

   // Response word.
   typedef struct packed {
      logic [STATUS_W-1:0] rsp_status;
      logic [SLOTF_W-1:0]  rsp_slot;
      logic                rsp_slot_valid;
      logic [KEY_BITS-1:0] rsp_key_out;
      logic [HASH_W-1:0]   rsp_hash_first_out;
      logic [HASH_W-1:0]   rsp_hash_second_out;
      logic [COUNT_W-1:0]  rsp_used_count;
   } rsp_word_type;

endpackage

FILE: hw/rtl/cht_if.sv
// Valid/ready channel interface with a generic payload.
interface cht_if #(
   parameter type PAYLOAD_TYPE = logic
);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/cuckoo_hash_table_top.sv
// Top level of the two-choice cuckoo hash table.
//
// Channels: req carries one request word (func, key, hash_first, hash_second,
// slot_index) and rsp returns exactly one response word (status, slot,
// slot_valid, key_out, hash_first_out, hash_second_out, used_count), both
// valid/ready. csr_wr_en/csr_wr_data set the eviction depth (reset 8); write
// it only while no request is in flight. Hashes are masked to the slot bits.
// Insert and find probe the first slot, then the second; an insert that misses
// both walks displacements up to the eviction depth, then fails. Erase and
// read go straight to the slot named by slot_index.
// Each walk step is a registered read of the single-port store, a check of
// the valid bit, then a write of the carried entry, all on the one store port.
// One request is in flight at a time: req_ready is high only in idle, which
// follows each delivered response, so a new request waits for that delivery.
// Reset zeroes the occupancy count and starts a clearing pass that writes the
// valid bits low one slot a cycle, over all 1024 slots, with req_ready held low.
// A stalled response is held in the output register, and no new request
// is taken until it is delivered.
module cuckoo_hash_table_top (
   input  logic                     clock,
   input  logic                     reset,
   cht_if.sink                      req,
   cht_if.source                    rsp,
   input  logic                     csr_wr_en,
   input  logic [cht_pkg::DEPTH_W-1:0] csr_wr_data
);
   localparam int IDX_W = cht_pkg::IDX_W;
   localparam int CNT_W = cht_pkg::COUNT_W;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDA  = 4'd1;
   localparam logic [3:0] S_CHKA = 4'd2;
   localparam logic [3:0] S_RDB  = 4'd3;
   localparam logic [3:0] S_CHKB = 4'd4;
   localparam logic [3:0] S_EVRD = 4'd5;
   localparam logic [3:0] S_EVCK = 4'd6;
   localparam logic [3:0] S_EVWR = 4'd7;
   localparam logic [3:0] S_SLRD = 4'd8;
   localparam logic [3:0] S_SLCK = 4'd9;
   localparam logic [3:0] S_RESP = 4'd10;
   localparam logic [3:0] S_CLR  = 4'd11;

   logic [3:0]                 state_ff, state_in;
   logic [cht_pkg::DEPTH_W-1:0] evict_ff;
   logic [cht_pkg::DEPTH_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [IDX_W-1:0]           clr_ff, clr_in;
   logic [1:0]                 func_ff, func_in;
   logic [cht_pkg::KEY_BITS-1:0] ckey_ff, ckey_in;
   logic [cht_pkg::HASH_W-1:0] c1_ff, c1_in, c2_ff, c2_in;
   logic [IDX_W-1:0]           pos_ff, pos_in, slotb_ff, slotb_in;
   logic [cht_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [IDX_W-1:0]           oslot_ff, oslot_in;
   logic                       osv_ff, osv_in;
   logic [cht_pkg::KEY_BITS-1:0] ok_ff, ok_in;
   logic [cht_pkg::HASH_W-1:0] o1_ff, o1_in, o2_ff, o2_in;

   cht_pkg::mem_cmd_type       cmd;
   logic [IDX_W-1:0]           addr;
   logic [cht_pkg::KEY_BITS-1:0] rd_key;
   logic [cht_pkg::HASH_W-1:0] rd_h1, rd_h2;
   logic                       rd_valid;
   logic                       hit;
   logic [IDX_W-1:0]           r1, r2;

   cht_store u_store (
      .clock    (clock),
      .cmd      (cmd),
      .addr     (addr),
      .wr_key   (ckey_ff),
      .wr_h1    (c1_ff),
      .wr_h2    (c2_ff),
      .rd_key   (rd_key),
      .rd_h1    (rd_h1),
      .rd_h2    (rd_h2),
      .rd_valid (rd_valid)
   );

   // Reduce a raw hash to a slot: the depth is a power of two, so keep the low bits.
   function automatic logic [IDX_W-1:0] reduce(input logic [cht_pkg::HASH_W-1:0] h);
      return h[IDX_W-1:0];
   endfunction

   assign hit = rd_valid && (rd_key == ckey_ff);
   assign r1  = reduce(rd_h1);
   assign r2  = reduce(rd_h2);

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_RESP);
   assign rsp.payload.rsp_status          = st_ff;
   assign rsp.payload.rsp_slot            = oslot_ff;
   assign rsp.payload.rsp_slot_valid      = osv_ff;
   assign rsp.payload.rsp_key_out         = ok_ff;
   assign rsp.payload.rsp_hash_first_out  = o1_ff;
   assign rsp.payload.rsp_hash_second_out = o2_ff;
   assign rsp.payload.rsp_used_count      = count_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      count_in = count_ff;
      clr_in   = clr_ff;
      func_in  = func_ff;
      ckey_in  = ckey_ff;
      c1_in    = c1_ff;
      c2_in    = c2_ff;
      pos_in   = pos_ff;
      slotb_in = slotb_ff;
      st_in    = st_ff;
      oslot_in = oslot_ff;
      osv_in   = osv_ff;
      ok_in    = ok_ff;
      o1_in    = o1_ff;
      o2_in    = o2_ff;
      cmd      = '0;
      addr     = pos_ff;
      case (state_ff)
         S_CLR: begin
            // Clear one valid bit per cycle after reset.
            cmd.clr_valid = 1'b1;
            addr          = clr_ff;
            clr_in        = clr_ff + 1'b1;
            if (clr_ff == cht_pkg::LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               func_in  = req.payload.req_func;
               ckey_in  = req.payload.req_key;
               c1_in    = req.payload.req_hash_first;
               c2_in    = req.payload.req_hash_second;
               pos_in   = reduce(req.payload.req_hash_first);
               slotb_in = reduce(req.payload.req_hash_second);
               osv_in   = 1'b0;
               ok_in    = '0;
               o1_in    = '0;
               o2_in    = '0;
               oslot_in = '0;
               if (req.payload.req_func == cht_pkg::FUNC_ERASE ||
                   req.payload.req_func == cht_pkg::FUNC_READ) begin
                  pos_in   = req.payload.req_slot_index[IDX_W-1:0];
                  state_in = S_SLRD;
               end else begin
                  state_in = S_RDA;
               end
            end
         end
         S_RDA: begin
            cmd.rd   = 1'b1;
            state_in = S_CHKA;
         end
         S_CHKA: begin
            if (hit) begin
               st_in    = (func_ff == cht_pkg::FUNC_INSERT) ?
                          cht_pkg::ST_PRESENT : cht_pkg::ST_FOUND;
               oslot_in = pos_ff;
               state_in = S_RESP;
            end else begin
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            cmd.rd   = 1'b1;
            addr     = slotb_ff;
            state_in = S_CHKB;
         end
         S_CHKB: begin
            step_in = '0;
            if (hit) begin
               st_in    = (func_ff == cht_pkg::FUNC_INSERT) ?
                          cht_pkg::ST_PRESENT : cht_pkg::ST_FOUND;
               oslot_in = slotb_ff;
               state_in = S_RESP;
            end else if (func_ff == cht_pkg::FUNC_FIND) begin
               st_in    = cht_pkg::ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               state_in = S_EVRD;
            end
         end
         S_EVRD: begin
            // Fail when the walk budget is spent; return the carried key.
            if (step_ff >= evict_ff) begin
               st_in    = cht_pkg::ST_FAILED;
               ok_in    = ckey_ff;
               o1_in    = c1_ff;
               o2_in    = c2_ff;
               state_in = S_RESP;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_EVCK;
            end
         end
         S_EVCK: begin
            // Write the carried entry here either way.
            cmd.wr = 1'b1;
            if (!rd_valid) begin
               cmd.set_valid = 1'b1;
               count_in = count_ff + 1'b1;
               st_in    = cht_pkg::ST_PLACED;
               oslot_in = pos_ff;
               state_in = S_RESP;
            end else begin
               state_in = S_EVWR;
            end
         end
         S_EVWR: begin
            // Pick up the displaced occupant and move to its other slot.
            ckey_in  = rd_key;
            c1_in    = rd_h1;
            c2_in    = rd_h2;
            pos_in   = (pos_ff == r1) ? r2 : r1;
            step_in  = step_ff + 1'b1;
            state_in = S_EVRD;
         end
         S_SLRD: begin
            // Read the slot first; erase needs its valid bit for the count.
            cmd.rd   = 1'b1;
            oslot_in = pos_ff;
            st_in    = (func_ff == cht_pkg::FUNC_ERASE) ?
                       cht_pkg::ST_ERASED : cht_pkg::ST_READ;
            state_in = S_SLCK;
         end
         S_SLCK: begin
            if (func_ff == cht_pkg::FUNC_ERASE) begin
               if (rd_valid) begin
                  cmd.clr_valid = 1'b1;
                  count_in      = count_ff - 1'b1;
               end
            end else begin
               osv_in = rd_valid;
               ok_in  = rd_key;
               o1_in  = rd_h1;
               o2_in  = rd_h2;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         evict_ff <= cht_pkg::EVICT_RESET;
         count_ff <= '0;
         step_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         step_ff  <= step_in;
         clr_ff   <= clr_in;
         if (csr_wr_en) begin
            evict_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      ckey_ff  <= ckey_in;
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      pos_ff   <= pos_in;
      slotb_ff <= slotb_in;
      st_ff    <= st_in;
      oslot_ff <= oslot_in;
      osv_ff   <= osv_in;
      ok_ff    <= ok_in;
      o1_ff    <= o1_in;
      o2_ff    <= o2_in;
   end
endmodule

FILE: hw/rtl/cht_store.sv
// Slot store: key, hash and valid-bit memories with a registered read port.
module cht_store (
   input  logic                         clock,
   input  cht_pkg::mem_cmd_type         cmd,
   input  logic [cht_pkg::IDX_W-1:0]    addr,
   input  logic [cht_pkg::KEY_BITS-1:0] wr_key,
   input  logic [cht_pkg::HASH_W-1:0]   wr_h1,
   input  logic [cht_pkg::HASH_W-1:0]   wr_h2,
   output logic [cht_pkg::KEY_BITS-1:0] rd_key,
   output logic [cht_pkg::HASH_W-1:0]   rd_h1,
   output logic [cht_pkg::HASH_W-1:0]   rd_h2,
   output logic                         rd_valid
);
   logic [cht_pkg::KEY_BITS-1:0] key_mem   [cht_pkg::TABLE_DEPTH];
   logic [cht_pkg::HASH_W-1:0]   h1_mem    [cht_pkg::TABLE_DEPTH];
   logic [cht_pkg::HASH_W-1:0]   h2_mem    [cht_pkg::TABLE_DEPTH];
   logic                         valid_mem [cht_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         key_mem[addr] <= wr_key;
         h1_mem[addr]  <= wr_h1;
         h2_mem[addr]  <= wr_h2;
      end
      if (cmd.rd) begin
         rd_key <= key_mem[addr];
         rd_h1  <= h1_mem[addr];
         rd_h2  <= h2_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.set_valid) begin
         valid_mem[addr] <= 1'b1;
      end else if (cmd.clr_valid) begin
         valid_mem[addr] <= 1'b0;
      end
      if (cmd.rd) begin
         rd_valid <= valid_mem[addr];
      end
   end
endmodule

FILE: hw/rtl/cht_checker.sv
// Port-level checker for the cuckoo hash table, bound to the top level.
module cht_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic        rsp_slot_valid,
   input logic [10:0] rsp_used_count
);
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while response pending");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid) else $error("request withdrawn");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");
   a_sv_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_valid |-> rsp_status == cht_pkg::ST_READ)
      else $error("slot_valid outside read");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_count <= 11'd1024) else $error("count too high");
endmodule

bind cuckoo_hash_table_top cht_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_status     (rsp.payload.rsp_status),
   .rsp_slot_valid (rsp.payload.rsp_slot_valid),
   .rsp_used_count (rsp.payload.rsp_used_count)
);

FILE: dv/cuckoo_hash_table_top_tb.sv
// Self-checking testbench for the two-choice cuckoo hash table top level.
`timescale 1ns / 100ps

module cuckoo_hash_table_top_tb;

   localparam int DEPTH      = cht_pkg::TABLE_DEPTH;
   localparam int POOL_SIZE  = 96;
   localparam int CYCLE_CAP  = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [cht_pkg::DEPTH_W-1:0] csr_wr_data = '0;

   cht_if #(.PAYLOAD_TYPE(cht_pkg::req_word_type)) req ();
   cht_if #(.PAYLOAD_TYPE(cht_pkg::rsp_word_type)) rsp ();

   cuckoo_hash_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // Shadow copy of the slot store and the eviction depth register.
   logic [31:0]        tbl_key   [DEPTH];
   logic [31:0]        tbl_h1    [DEPTH];
   logic [31:0]        tbl_h2    [DEPTH];
   bit                 tbl_valid [DEPTH];
   bit                 tbl_written [DEPTH];
   logic [cht_pkg::COUNT_W-1:0] tbl_count;
   logic [cht_pkg::DEPTH_W-1:0] evict_limit;
   logic [cht_pkg::DEPTH_W-1:0] depth_list [5];

   cht_pkg::req_word_type send_q[$];
   cht_pkg::rsp_word_type expected_q[$];
   int         written_slots[$];
   int         errors = 0;
   int         cycles = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_asked = 0;
   int         hold_done = 0;
   int         hold_left = 0;

   // Key pool: hashes crowd into a few dozen slots so chains form often.
   logic [31:0] pool_key [POOL_SIZE];
   logic [31:0] pool_h1  [POOL_SIZE];
   logic [31:0] pool_h2  [POOL_SIZE];

   function automatic void mark_written(int s);
      if (!tbl_written[s]) begin
         tbl_written[s] = 1'b1;
         written_slots.push_back(s);
      end
   endfunction

   // Work out the response word of one accepted request, updating the shadow.
   function automatic cht_pkg::rsp_word_type table_outcome(cht_pkg::req_word_type w);
      cht_pkg::rsp_word_type r;
      logic [cht_pkg::IDX_W-1:0] a, b, pos;
      int n;
      logic [31:0] ck, c1, c2, tk, t1, t2;
      bit placed;
      r = '0;
      a = w.req_hash_first[cht_pkg::IDX_W-1:0];
      b = w.req_hash_second[cht_pkg::IDX_W-1:0];
      case (w.req_func)
         cht_pkg::FUNC_INSERT, cht_pkg::FUNC_FIND: begin
            if (tbl_valid[a] && tbl_key[a] == w.req_key) begin
               r.rsp_status = (w.req_func == cht_pkg::FUNC_INSERT) ?
                              cht_pkg::ST_PRESENT : cht_pkg::ST_FOUND;
               r.rsp_slot = a;
            end else if (tbl_valid[b] && tbl_key[b] == w.req_key) begin
               r.rsp_status = (w.req_func == cht_pkg::FUNC_INSERT) ?
                              cht_pkg::ST_PRESENT : cht_pkg::ST_FOUND;
               r.rsp_slot = b;
            end else if (w.req_func == cht_pkg::FUNC_FIND) begin
               r.rsp_status = cht_pkg::ST_NOT_FOUND;
            end else begin
               ck = w.req_key; c1 = w.req_hash_first; c2 = w.req_hash_second;
               pos = a;
               placed = 1'b0;
               for (n = 0; n < evict_limit && !placed; n++) begin
                  if (!tbl_valid[pos]) begin
                     tbl_key[pos] = ck; tbl_h1[pos] = c1; tbl_h2[pos] = c2;
                     tbl_valid[pos] = 1'b1;
                     mark_written(pos);
                     tbl_count++;
                     r.rsp_status = cht_pkg::ST_PLACED;
                     r.rsp_slot = pos;
                     placed = 1'b1;
                  end else begin
                     // Swap in the carried key and carry the occupant on.
                     tk = tbl_key[pos]; t1 = tbl_h1[pos]; t2 = tbl_h2[pos];
                     tbl_key[pos] = ck; tbl_h1[pos] = c1; tbl_h2[pos] = c2;
                     ck = tk; c1 = t1; c2 = t2;
                     pos = (pos == c1[cht_pkg::IDX_W-1:0]) ?
                           c2[cht_pkg::IDX_W-1:0] : c1[cht_pkg::IDX_W-1:0];
                  end
               end
               if (!placed) begin
                  r.rsp_status = cht_pkg::ST_FAILED;
                  r.rsp_key_out = ck;
                  r.rsp_hash_first_out = c1;
                  r.rsp_hash_second_out = c2;
               end
            end
         end
         cht_pkg::FUNC_ERASE: begin
            if (tbl_valid[w.req_slot_index]) begin
               tbl_valid[w.req_slot_index] = 1'b0;
               if (tbl_count > 0) tbl_count--;
            end
            r.rsp_status = cht_pkg::ST_ERASED;
            r.rsp_slot = w.req_slot_index;
         end
         default: begin
            r.rsp_status = cht_pkg::ST_READ;
            r.rsp_slot = w.req_slot_index;
            r.rsp_slot_valid = tbl_valid[w.req_slot_index];
            r.rsp_key_out = tbl_key[w.req_slot_index];
            r.rsp_hash_first_out = tbl_h1[w.req_slot_index];
            r.rsp_hash_second_out = tbl_h2[w.req_slot_index];
         end
      endcase
      r.rsp_used_count = tbl_count;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
   endtask

   // Driver: advance to the next queued word once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.payload <= '0;
      end else if (!req.valid || req.ready) begin
         if (req.valid && req.ready) expected_q.push_back(table_outcome(req.payload));
         if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req.valid <= 1'b1;
            req.payload <= send_q.pop_front();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted here; the monitor only looks at hold_left.
   always @(posedge clock) begin
      if (hold_asked != hold_done) begin
         hold_done <= hold_asked;
         hold_left <= 400;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: compare every delivered word with the oldest prediction.
   always @(posedge clock) begin
      cht_pkg::rsp_word_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected word", rsp.payload.rsp_status, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp.payload.rsp_status !== want.rsp_status)
                  report_mismatch("status", rsp.payload.rsp_status, want.rsp_status);
               if (rsp.payload.rsp_slot !== want.rsp_slot)
                  report_mismatch("slot", rsp.payload.rsp_slot, want.rsp_slot);
               if (rsp.payload.rsp_slot_valid !== want.rsp_slot_valid)
                  report_mismatch("slot_valid", rsp.payload.rsp_slot_valid,
                                  want.rsp_slot_valid);
               if (rsp.payload.rsp_key_out !== want.rsp_key_out)
                  report_mismatch("key_out", rsp.payload.rsp_key_out, want.rsp_key_out);
               if (rsp.payload.rsp_hash_first_out !== want.rsp_hash_first_out)
                  report_mismatch("hash_first_out", rsp.payload.rsp_hash_first_out,
                                  want.rsp_hash_first_out);
               if (rsp.payload.rsp_hash_second_out !== want.rsp_hash_second_out)
                  report_mismatch("hash_second_out", rsp.payload.rsp_hash_second_out,
                                  want.rsp_hash_second_out);
               if (rsp.payload.rsp_used_count !== want.rsp_used_count)
                  report_mismatch("used_count", rsp.payload.rsp_used_count,
                                  want.rsp_used_count);
            end
         end
         rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic cht_pkg::req_word_type make_word(logic [1:0] f, logic [31:0] k,
                                                       logic [31:0] h1, logic [31:0] h2,
                                                       logic [9:0] s);
      cht_pkg::req_word_type w;
      w.req_func = f; w.req_key = k; w.req_hash_first = h1; w.req_hash_second = h2;
      w.req_slot_index = s;
      return w;
   endfunction

   // Mostly pool keys with consistent hashes; some noise with random hashes.
   function automatic cht_pkg::req_word_type random_word();
      int p, pick;
      logic [1:0] f;
      pick = $urandom_range(99);
      p = $urandom_range(POOL_SIZE - 1);
      if (pick < 50) f = cht_pkg::FUNC_INSERT;
      else if (pick < 72) f = cht_pkg::FUNC_FIND;
      else if (pick < 86) f = cht_pkg::FUNC_ERASE;
      else f = cht_pkg::FUNC_READ;
      if (f == cht_pkg::FUNC_READ) begin
         // Read only slots that have held an entry at some point.
         if (written_slots.size() == 0) f = cht_pkg::FUNC_FIND;
         else return make_word(f, $urandom, $urandom, $urandom,
                               10'(written_slots[$urandom_range(written_slots.size() - 1)]));
      end
      if ($urandom_range(9) == 0)
         return make_word(f, $urandom, $urandom, $urandom, 10'($urandom));
      if (f == cht_pkg::FUNC_ERASE && $urandom_range(1))
         return make_word(f, $urandom, $urandom, $urandom,
                          pool_h1[p][9:0] ^ ($urandom_range(1) ? 10'd0 : pool_h2[p][9:0]));
      return make_word(f, pool_key[p], pool_h1[p], pool_h2[p], 10'($urandom));
   endfunction

   task automatic drain();
      @(negedge clock);
      while (send_q.size() > 0 || expected_q.size() > 0 || req.valid) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_depth(logic [cht_pkg::DEPTH_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      evict_limit = v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int i, ph;
      depth_list[0] = 7'd1;
      depth_list[1] = 7'd64;
      depth_list[2] = 7'd127;
      depth_list[3] = 7'd3;
      depth_list[4] = 7'd16;
      for (i = 0; i < DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_written[i] = 1'b0;
      end
      tbl_count = '0;
      evict_limit = cht_pkg::EVICT_RESET;
      for (i = 0; i < POOL_SIZE; i++) begin
         pool_key[i] = $urandom;
         pool_h1[i]  = {22'($urandom_range(32'h3FFFFF)), 10'($urandom_range(47))};
         pool_h2[i]  = {22'($urandom_range(32'h3FFFFF)), 10'($urandom_range(47))};
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset depth: hit, miss, erase, stale read, chains.
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0, 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0, 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_FIND, 32'h0, 32'h0, 32'hFFFF_FFFF, 10'h3FF));
      send_q.push_back(make_word(cht_pkg::FUNC_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                                 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 10'h3FF));
      send_q.push_back(make_word(cht_pkg::FUNC_ERASE, 32'h0, 32'h0, 32'h0, 10'h3FF));
      send_q.push_back(make_word(cht_pkg::FUNC_ERASE, 32'h0, 32'h0, 32'h0, 10'h3FF));
      send_q.push_back(make_word(cht_pkg::FUNC_READ, 32'hFFFF_FFFF, 32'h0, 32'h0, 10'h3FF));
      send_q.push_back(make_word(cht_pkg::FUNC_ERASE, 32'h0, 32'h0, 32'h0, 10'h155));
      // Three keys sharing slot 5 with alternates 6 and 7 force displacement.
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'h11, 32'h5, 32'h6, 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'h22, 32'h5, 32'h7, 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'h33, 32'h5, 32'h6, 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_FIND, 32'h11, 32'h5, 32'h6, 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 10'h6));
      send_q.push_back(make_word(cht_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 10'h7));
      drain();
      // Depth zero: a fresh key fails at once and comes back unchanged.
      set_depth(7'd0);
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'hAAAA_5555, 32'h8, 32'h9, 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'h33, 32'h5, 32'h6, 10'h0));
      drain();
      // Depth one on a full pair of slots: failure returns a displaced key.
      set_depth(7'd1);
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'h44, 32'h5, 32'h7, 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_READ, 32'h0, 32'h0, 32'h0, 10'h5));
      drain();
      // Depth above 64 is honored in full.
      set_depth(7'd127);
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'h55, 32'h6, 32'h7, 10'h0));
      send_q.push_back(make_word(cht_pkg::FUNC_INSERT, 32'h5555_AAAA, 32'h5555_AAAA,
                                 32'hAAAA_5555, 10'h0));
      drain();

      // Random part: idling changes with each third of the run.
      for (ph = 0; ph < 15; ph++) begin
         case (ph / 5)
            0: begin send_idle_pct = 13; recv_idle_pct = 58; end
            1: begin send_idle_pct = 58; recv_idle_pct = 13; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         set_depth(depth_list[ph % 5]);
         // Keep the table from saturating: clear it out now and then.
         if (ph % 4 == 3)
            for (i = 0; i < 64; i++)
               send_q.push_back(make_word(cht_pkg::FUNC_ERASE, $urandom, $urandom, $urandom,
                                          10'(i)));
         for (i = 0; i < 112; i++) send_q.push_back(random_word());
         // Hold the receiver off while the sender keeps offering words.
         if (ph == 2 || ph == 12) hold_asked++;
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
